// ----- src/cfpr_pkg.sv -----
// Shared types, constants and helpers for the complex float product reduction.
// Depends on nothing; every other file refers to it by scoped names.
package cfpr_pkg;

   // Binary64 encodings used by the datapath.
   localparam logic [63:0] FP_ONE     = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] FP_ZERO    = 64'h0000_0000_0000_0000;
   localparam logic [63:0] FP_QNAN    = 64'h7FF8_0000_0000_0000;
   localparam logic [62:0] FP_INF_MAG = 63'h7FF0_0000_0000_0000;

   // Configuration port shape and register indexes.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COMPLEX_MODE = 2'd0,
      CSR_INCLUDE_NAN  = 2'd1
   } csr_index_type;

   // Operations of the shared floating-point unit.
   typedef enum logic [1:0] {
      FOP_MUL = 2'd0,
      FOP_ADD = 2'd1,
      FOP_SUB = 2'd2
   } fpu_op_type;

   // Element queue between the front and the back.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   // Operation sequence of the back end: four products, then two sums in complex mode; a single product in real mode.
   localparam int          OP_IDX_W     = 3;
   localparam logic [2:0]  OP_LAST_CPLX = 3'd5;
   localparam logic [2:0]  OP_LAST_REAL = 3'd0;
   localparam int          NUM_TEMPS    = 6;

   // One classified element as it waits in the queue.
   typedef struct packed {
      logic [63:0] re;
      logic [63:0] im;
      logic        last;
      logic        skip;
      logic        cmode;
   } elem_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic              valid;
      elem_type          elem;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   // Request and response of the shared floating-point unit.
   typedef struct packed {
      logic        start;
      fpu_op_type  op;
      logic [63:0] a;
      logic [63:0] b;
   } fpu_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] result;
   } fpu_rsp_type;

   // True for any NaN bit pattern, whatever its sign or payload.
   function automatic logic is_nan(input logic [63:0] bits);
      return bits[62:0] > FP_INF_MAG;
   endfunction

endpackage

// ----- src/cfpr_if.sv -----
// Handshake channels of the complex float product reduction.
// Depends on cfpr_pkg for the configuration port widths.
interface cfpr_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] re_value;
   logic [63:0] im_value;
   logic        line_end;
   modport source (output valid, re_value, im_value, line_end, input ready);
   modport sink   (input valid, re_value, im_value, line_end, output ready);
endinterface

interface cfpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] prod_re;
   logic [63:0] prod_im;
   modport source (output valid, prod_re, prod_im, input ready);
   modport sink   (input valid, prod_re, prod_im, output ready);
endinterface

interface cfpr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [cfpr_pkg::CSR_IDX_W-1:0]   index;
   logic [cfpr_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/cfpr_front.sv -----
// Front end: configuration registers, NaN classification and the element queue.
// Depends on cfpr_pkg and the channel interfaces in cfpr_if.sv.
module cfpr_front (
   input  logic                       clock,
   input  logic                       reset,
   cfpr_req_if.sink                   req_ch,
   cfpr_csr_if.sink                   csr_ch,
   input  logic                       q_pop,
   output cfpr_pkg::queue_status_type q_st
);

   logic                           cmode_ff, cmode_in;
   logic                           incnan_ff, incnan_in;
   cfpr_pkg::elem_type             q_ff [cfpr_pkg::QDEPTH];
   logic [cfpr_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [cfpr_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [cfpr_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                           push;
   cfpr_pkg::elem_type             new_elem;

   // Configuration writes are always taken.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cmode_in  = cmode_ff;
      incnan_in = incnan_ff;
      if (csr_ch.valid) begin
         case (cfpr_pkg::csr_index_type'(csr_ch.index))
            cfpr_pkg::CSR_COMPLEX_MODE: cmode_in  = csr_ch.data[0];
            cfpr_pkg::CSR_INCLUDE_NAN:  incnan_in = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // Classify the incoming item: the mode in force and whether it is skipped.
   always_comb begin
      new_elem.re    = req_ch.re_value;
      new_elem.im    = req_ch.im_value;
      new_elem.last  = req_ch.line_end;
      new_elem.cmode = cmode_ff;
      if (cmode_ff) begin
         new_elem.skip = !incnan_ff && (cfpr_pkg::is_nan(req_ch.re_value) ||
                                        cfpr_pkg::is_nan(req_ch.im_value));
      end else begin
         new_elem.skip = !incnan_ff && cfpr_pkg::is_nan(req_ch.re_value);
      end
   end

   // Queue pointers and fill count.
   assign req_ch.ready = (count_ff != cfpr_pkg::QCNT_W'(cfpr_pkg::QDEPTH));
   assign push         = req_ch.valid && req_ch.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmode_ff  <= 1'b0;
         incnan_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         cmode_ff  <= cmode_in;
         incnan_ff <= incnan_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_elem;
      end
   end

   assign q_st.valid = (count_ff != '0);
   assign q_st.elem  = q_ff[rd_ptr_ff];
   assign q_st.count = count_ff;

endmodule

// ----- src/cfpr_fpu.sv -----
// Shared binary64 multiply/add unit, one operation at a time, round to nearest even.
// Depends on cfpr_pkg for the request/response structs and encodings.
module cfpr_fpu (
   input  logic                  clock,
   input  logic                  reset,
   input  cfpr_pkg::fpu_req_type fpu_req,
   output cfpr_pkg::fpu_rsp_type fpu_rsp
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MUL   = 7'b0000010,
      S_ALIGN = 7'b0000100,
      S_SUM   = 7'b0001000,
      S_NORM  = 7'b0010000,
      S_PACK  = 7'b0100000,
      S_ROUND = 7'b1000000
   } fpu_state_type;

   fpu_state_type        state_ff, state_in;
   cfpr_pkg::fpu_op_type op_ff, op_in;
   logic [63:0]          a_ff, a_in, b_ff, b_in;
   logic [2:0]           step_ff, step_in;
   logic [105:0]         sig_ff, sig_in;
   logic [13:0]          exp_ff, exp_in;
   logic                 sign_ff, sign_in;
   logic                 zsgn_ff, zsgn_in;
   logic                 esub_ff, esub_in;
   logic [55:0]          lsig_ff, lsig_in, ssig_ff, ssig_in;
   logic [62:0]          word_ff, word_in;
   logic                 grd_ff, grd_in, stk_ff, stk_in;
   logic                 zero_ff, zero_in, ovf_ff, ovf_in;
   logic [63:0]          result_ff, result_in;
   logic                 done_ff, done_in;

   // Unpacked operands.
   logic [10:0] a_exp, b_exp, a_eexp, b_eexp;
   logic [52:0] a_man, b_man;
   logic        b_sgn_eff;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic        spec_hit;
   logic [63:0] spec_bits;

   always_comb begin
      a_exp     = a_ff[62:52];
      b_exp     = b_ff[62:52];
      a_man     = {(a_exp != 11'd0), a_ff[51:0]};
      b_man     = {(b_exp != 11'd0), b_ff[51:0]};
      a_eexp    = (a_exp == 11'd0) ? 11'd1 : a_exp;
      b_eexp    = (b_exp == 11'd0) ? 11'd1 : b_exp;
      b_sgn_eff = b_ff[63] ^ (op_ff == cfpr_pkg::FOP_SUB);
      a_nan     = cfpr_pkg::is_nan(a_ff);
      b_nan     = cfpr_pkg::is_nan(b_ff);
      a_inf     = (a_ff[62:0] == cfpr_pkg::FP_INF_MAG);
      b_inf     = (b_ff[62:0] == cfpr_pkg::FP_INF_MAG);
      a_zero    = (a_ff[62:0] == 63'd0);
      b_zero    = (b_ff[62:0] == 63'd0);
   end

   // NaN and infinity operands override the datapath result.
   always_comb begin
      spec_hit  = 1'b0;
      spec_bits = cfpr_pkg::FP_QNAN;
      if (op_ff == cfpr_pkg::FOP_MUL) begin
         if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
            spec_hit = 1'b1;
         end else if (a_inf || b_inf) begin
            spec_hit  = 1'b1;
            spec_bits = {a_ff[63] ^ b_ff[63], cfpr_pkg::FP_INF_MAG};
         end
      end else begin
         if (a_nan || b_nan || (a_inf && b_inf && (a_ff[63] != b_sgn_eff))) begin
            spec_hit = 1'b1;
         end else if (a_inf) begin
            spec_hit  = 1'b1;
            spec_bits = {a_ff[63], cfpr_pkg::FP_INF_MAG};
         end else if (b_inf) begin
            spec_hit  = 1'b1;
            spec_bits = {b_sgn_eff, cfpr_pkg::FP_INF_MAG};
         end
      end
   end

   // One 27x27 partial product of the 53x53 significand product per cycle.
   logic [26:0]  mx, my;
   logic [53:0]  pp;
   logic [105:0] pp_sh;

   always_comb begin
      case (step_ff[1:0])
         2'd0: begin
            mx    = a_man[26:0];
            my    = b_man[26:0];
         end
         2'd1: begin
            mx    = a_man[26:0];
            my    = {1'b0, b_man[52:27]};
         end
         2'd2: begin
            mx    = {1'b0, a_man[52:27]};
            my    = b_man[26:0];
         end
         default: begin
            mx    = {1'b0, a_man[52:27]};
            my    = {1'b0, b_man[52:27]};
         end
      endcase
      pp = mx * my;
      case (step_ff[1:0])
         2'd0:    pp_sh = {52'd0, pp};
         2'd1:    pp_sh = {25'd0, pp, 27'd0};
         2'd2:    pp_sh = {25'd0, pp, 27'd0};
         default: pp_sh = {pp[51:0], 54'd0};
      endcase
   end

   // Addition alignment: larger magnitude first, smaller shifted with sticky.
   logic        swap;
   logic [52:0] l_man, s_man;
   logic [10:0] l_eexp, s_eexp, shamt;
   logic        l_sgn, s_sgn;
   logic [55:0] s_ext, s_shr;
   logic        s_lost;

   always_comb begin
      swap   = (b_ff[62:0] > a_ff[62:0]);
      l_man  = swap ? b_man : a_man;
      s_man  = swap ? a_man : b_man;
      l_eexp = swap ? b_eexp : a_eexp;
      s_eexp = swap ? a_eexp : b_eexp;
      l_sgn  = swap ? b_sgn_eff : a_ff[63];
      s_sgn  = swap ? a_ff[63] : b_sgn_eff;
      shamt  = l_eexp - s_eexp;
      s_ext  = {s_man, 3'b000};
      s_shr  = s_ext >> shamt;
      s_lost = |(s_ext & ~({56{1'b1}} << shamt));
   end

   logic [56:0] sum;
   assign sum = esub_ff ? ({1'b0, lsig_ff} - {1'b0, ssig_ff})
                        : ({1'b0, lsig_ff} + {1'b0, ssig_ff});

   // Normalization: shift by 64, 32, ... 1 in successive cycles.
   logic       nz_hit;
   logic [6:0] nshift;

   always_comb begin
      case (step_ff)
         3'd0: begin
            nz_hit = (sig_ff[105:42] == 64'd0);
            nshift = 7'd64;
         end
         3'd1: begin
            nz_hit = (sig_ff[105:74] == 32'd0);
            nshift = 7'd32;
         end
         3'd2: begin
            nz_hit = (sig_ff[105:90] == 16'd0);
            nshift = 7'd16;
         end
         3'd3: begin
            nz_hit = (sig_ff[105:98] == 8'd0);
            nshift = 7'd8;
         end
         3'd4: begin
            nz_hit = (sig_ff[105:102] == 4'd0);
            nshift = 7'd4;
         end
         3'd5: begin
            nz_hit = (sig_ff[105:104] == 2'd0);
            nshift = 7'd2;
         end
         default: begin
            nz_hit = !sig_ff[105];
            nshift = 7'd1;
         end
      endcase
   end

   // Packing: biased exponent, subnormal right shift with sticky.
   logic signed [13:0] be_s;
   logic [13:0]        be, den_sh;
   logic               den;
   logic [6:0]         den_sh_c;
   logic [105:0]       pk_sig;
   logic               pk_lost;

   always_comb begin
      be       = exp_ff + 14'd1128;
      be_s     = $signed(be);
      den      = (be_s <= 14'sd0);
      den_sh   = 14'd1 - be;
      den_sh_c = ($signed(den_sh) > 14'sd127) ? 7'd127 : den_sh[6:0];
      pk_sig   = den ? (sig_ff >> den_sh_c) : sig_ff;
      pk_lost  = den && (|(sig_ff & ~({106{1'b1}} << den_sh_c)));
   end

   logic        rnd;
   logic [62:0] rounded;
   assign rnd     = grd_ff && (stk_ff || word_ff[0]);
   assign rounded = word_ff + {62'd0, rnd};

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      step_in   = step_ff;
      sig_in    = sig_ff;
      exp_in    = exp_ff;
      sign_in   = sign_ff;
      zsgn_in   = zsgn_ff;
      esub_in   = esub_ff;
      lsig_in   = lsig_ff;
      ssig_in   = ssig_ff;
      word_in   = word_ff;
      grd_in    = grd_ff;
      stk_in    = stk_ff;
      zero_in   = zero_ff;
      ovf_in    = ovf_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (fpu_req.start) begin
               op_in    = fpu_req.op;
               a_in     = fpu_req.a;
               b_in     = fpu_req.b;
               step_in  = 3'd0;
               sig_in   = '0;
               state_in = (fpu_req.op == cfpr_pkg::FOP_MUL) ? S_MUL : S_ALIGN;
            end
         end
         S_MUL: begin
            sig_in = sig_ff + pp_sh;
            if (step_ff == 3'd0) begin
               exp_in  = {3'b000, a_eexp} + {3'b000, b_eexp} - 14'd2150;
               sign_in = a_ff[63] ^ b_ff[63];
            end
            if (step_ff == 3'd3) begin
               step_in  = 3'd0;
               state_in = S_NORM;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_ALIGN: begin
            lsig_in  = {l_man, 3'b000};
            ssig_in  = {s_shr[55:1], s_shr[0] | s_lost};
            esub_in  = l_sgn ^ s_sgn;
            exp_in   = {3'b000, l_eexp} - 14'd1078;
            sign_in  = l_sgn;
            zsgn_in  = l_sgn & s_sgn;
            state_in = S_SUM;
         end
         S_SUM: begin
            sig_in = {49'd0, sum};
            if (sum == 57'd0) begin
               sign_in = zsgn_ff;
            end
            step_in  = 3'd0;
            state_in = S_NORM;
         end
         S_NORM: begin
            if (nz_hit) begin
               sig_in = sig_ff << nshift;
               exp_in = exp_ff - {7'd0, nshift};
            end
            if (step_ff == 3'd6) begin
               state_in = S_PACK;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_PACK: begin
            zero_in  = !sig_ff[105];
            ovf_in   = (be_s >= 14'sd2047);
            word_in  = {(den ? 11'd0 : be[10:0]), pk_sig[104:53]};
            grd_in   = pk_sig[52];
            stk_in   = (|pk_sig[51:0]) | pk_lost;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            if (spec_hit) begin
               result_in = spec_bits;
            end else if (zero_ff) begin
               result_in = {sign_ff, 63'd0};
            end else if (ovf_ff) begin
               result_in = {sign_ff, cfpr_pkg::FP_INF_MAG};
            end else begin
               result_in = {sign_ff, rounded};
            end
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      step_ff   <= step_in;
      sig_ff    <= sig_in;
      exp_ff    <= exp_in;
      sign_ff   <= sign_in;
      zsgn_ff   <= zsgn_in;
      esub_ff   <= esub_in;
      lsig_ff   <= lsig_in;
      ssig_ff   <= ssig_in;
      word_ff   <= word_in;
      grd_ff    <= grd_in;
      stk_ff    <= stk_in;
      zero_ff   <= zero_in;
      ovf_ff    <= ovf_in;
      result_ff <= result_in;
   end

   assign fpu_rsp.busy   = (state_ff != S_IDLE);
   assign fpu_rsp.done   = done_ff;
   assign fpu_rsp.result = result_ff;

endmodule

// ----- src/cfpr_back.sv -----
// Back end: accumulator, operation sequencer over the shared FPU and the output register.
// Depends on cfpr_pkg (which holds the FPU request/response structs) and cfpr_if.sv.
module cfpr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  cfpr_pkg::queue_status_type q_st,
   output logic                       q_pop,
   output cfpr_pkg::fpu_req_type      fpu_req,
   input  cfpr_pkg::fpu_rsp_type      fpu_rsp,
   cfpr_rsp_if.source                 rsp_ch,
   output logic                       emit
);

   typedef enum logic [4:0] {
      B_IDLE   = 5'b00001,
      B_ISSUE  = 5'b00010,
      B_WAIT   = 5'b00100,
      B_COMMIT = 5'b01000,
      B_EMIT   = 5'b10000
   } back_state_type;

   back_state_type                 state_ff, state_in;
   cfpr_pkg::elem_type             elem_ff, elem_in;
   logic [cfpr_pkg::OP_IDX_W-1:0]  opi_ff, opi_in;
   logic [63:0]                    res_ff [cfpr_pkg::NUM_TEMPS];
   logic [63:0]                    acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic                           out_valid_ff, out_valid_in;
   logic [63:0]                    out_re_ff, out_re_in, out_im_ff, out_im_in;
   logic [cfpr_pkg::OP_IDX_W-1:0]  last_op;
   logic                           res_wr;

   assign last_op = elem_ff.cmode ? cfpr_pkg::OP_LAST_CPLX : cfpr_pkg::OP_LAST_REAL;

   // Operands of each step of the complex multiply.
   always_comb begin
      fpu_req.start = (state_ff == B_ISSUE);
      case (opi_ff)
         3'd0: begin
            fpu_req.op = cfpr_pkg::FOP_MUL;
            fpu_req.a  = acc_re_ff;
            fpu_req.b  = elem_ff.re;
         end
         3'd1: begin
            fpu_req.op = cfpr_pkg::FOP_MUL;
            fpu_req.a  = acc_im_ff;
            fpu_req.b  = elem_ff.im;
         end
         3'd2: begin
            fpu_req.op = cfpr_pkg::FOP_MUL;
            fpu_req.a  = acc_re_ff;
            fpu_req.b  = elem_ff.im;
         end
         3'd3: begin
            fpu_req.op = cfpr_pkg::FOP_MUL;
            fpu_req.a  = acc_im_ff;
            fpu_req.b  = elem_ff.re;
         end
         3'd4: begin
            fpu_req.op = cfpr_pkg::FOP_SUB;
            fpu_req.a  = res_ff[0];
            fpu_req.b  = res_ff[1];
         end
         3'd5: begin
            fpu_req.op = cfpr_pkg::FOP_ADD;
            fpu_req.a  = res_ff[2];
            fpu_req.b  = res_ff[3];
         end
         default: begin
            fpu_req.op = cfpr_pkg::FOP_MUL;
            fpu_req.a  = acc_re_ff;
            fpu_req.b  = elem_ff.re;
         end
      endcase
   end

   // Sequencer: take an element, run its operations, fold into the accumulator.
   always_comb begin
      state_in     = state_ff;
      elem_in      = elem_ff;
      opi_in       = opi_ff;
      acc_re_in    = acc_re_ff;
      acc_im_in    = acc_im_ff;
      out_re_in    = out_re_ff;
      out_im_in    = out_im_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      q_pop        = 1'b0;
      res_wr       = 1'b0;
      emit         = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (q_st.valid) begin
               q_pop    = 1'b1;
               elem_in  = q_st.elem;
               opi_in   = '0;
               state_in = q_st.elem.skip ? B_COMMIT : B_ISSUE;
            end
         end
         B_ISSUE: begin
            state_in = B_WAIT;
         end
         B_WAIT: begin
            if (fpu_rsp.done) begin
               res_wr = 1'b1;
               if (opi_ff == last_op) begin
                  state_in = B_COMMIT;
               end else begin
                  opi_in   = opi_ff + 1'b1;
                  state_in = B_ISSUE;
               end
            end
         end
         B_COMMIT: begin
            if (!elem_ff.skip) begin
               acc_re_in = elem_ff.cmode ? res_ff[4] : res_ff[0];
               acc_im_in = elem_ff.cmode ? res_ff[5] : acc_im_ff;
            end
            state_in = elem_ff.last ? B_EMIT : B_IDLE;
         end
         B_EMIT: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               emit         = 1'b1;
               out_valid_in = 1'b1;
               out_re_in    = acc_re_ff;
               out_im_in    = elem_ff.cmode ? acc_im_ff : cfpr_pkg::FP_ZERO;
               acc_re_in    = cfpr_pkg::FP_ONE;
               acc_im_in    = cfpr_pkg::FP_ZERO;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         acc_re_ff    <= cfpr_pkg::FP_ONE;
         acc_im_ff    <= cfpr_pkg::FP_ZERO;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_re_ff    <= acc_re_in;
         acc_im_ff    <= acc_im_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff   <= elem_in;
      opi_ff    <= opi_in;
      out_re_ff <= out_re_in;
      out_im_ff <= out_im_in;
      if (res_wr) begin
         res_ff[opi_ff] <= fpu_rsp.result;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.prod_re = out_re_ff;
   assign rsp_ch.prod_im = out_im_ff;

endmodule

// ----- src/complex_float_product_reduction.sv -----
// Top level of the complex float product reduction.
// Depends on cfpr_pkg, cfpr_if.sv, cfpr_front, cfpr_fpu and cfpr_back.
//
// Usage:
//   req_ch carries one binary64 element per item (re_value, im_value, line_end).
//   rsp_ch returns one item (prod_re, prod_im) for each element that carries
//   line_end: the product of the line, after which the product restarts at 1+0i.
//   csr_ch writes complex_mode (index 0) and include_nan (index 1) from bit 0 of
//   data and is always ready; the user is to write it only while the block is
//   idle, which the block itself does not enforce. Items pass through a
//   two-entry queue, so req_ch keeps accepting while the back end works and
//   while a finished result waits on rsp_ch.
//   All arithmetic runs on one shared binary64 unit, one operation at a time.
//   The back end pops an element, then issues each operation and waits for
//   its result, then commits: one multiply for a real-mode element, four
//   multiplies and two sums for a complex-mode element, none for a skipped one.
//   At a line end the emit state then loads the output register.
//   Reset (synchronous, active high) clears the queue, the configuration and
//   the output valid flag and sets the accumulator to 1+0i.
//   When rsp_ch stalls the result holds; the back end waits at the next line
//   end and the queue fills, after which req_ch drops ready.
module complex_float_product_reduction (
   input logic         clock,
   input logic         reset,
   cfpr_req_if.sink    req_ch,
   cfpr_rsp_if.source  rsp_ch,
   cfpr_csr_if.sink    csr_ch
);

   cfpr_pkg::queue_status_type q_st;
   logic                       q_pop;
   cfpr_pkg::fpu_req_type      fpu_req;
   cfpr_pkg::fpu_rsp_type      fpu_rsp;
   logic                       emit;

   cfpr_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .q_pop  (q_pop),
      .q_st   (q_st)
   );

   cfpr_fpu u_fpu (
      .clock   (clock),
      .reset   (reset),
      .fpu_req (fpu_req),
      .fpu_rsp (fpu_rsp)
   );

   cfpr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_st    (q_st),
      .q_pop   (q_pop),
      .fpu_req (fpu_req),
      .fpu_rsp (fpu_rsp),
      .rsp_ch  (rsp_ch),
      .emit    (emit)
   );

   // The back end only starts the FPU when it is free.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      fpu_req.start |-> !fpu_rsp.busy)
      else $error("FPU started while busy");

   // An element is only taken from a non-empty queue.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_st.valid)
      else $error("pop from empty queue");

   // A line result loaded into the output register is offered next cycle.
   a_emit_shown: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_ch.valid)
      else $error("emitted result not presented");

endmodule
